// ----- rtl/dsm_pkg.sv -----
// Shared types, request codes and character constants for the dot-star pattern matcher.
package dsm_pkg;

    localparam int MAX_TOKENS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] DOT_CHAR  = 8'h2E;
    localparam logic [7:0] STAR_CHAR = 8'h2A;

    typedef enum logic [1:0] {
        REQ_CLEAR   = 2'd0,
        REQ_PATTERN = 2'd1,
        REQ_TEXT    = 2'd2,
        REQ_END     = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t  req_type;
        logic [7:0] char_value;
    } in_word_t;

    typedef struct packed {
        logic matched;
        logic overflow;
    } out_word_t;

    // Classified word passed from front to back
    typedef struct packed {
        req_type_t  kind;
        logic       is_star;
        logic       is_dot;
        logic [7:0] char_value;
    } op_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- rtl/dsm_front.sv -----
// Front stage: accepts request words and classifies their characters.
module dsm_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dsm_pkg::in_word_t in_word,
    output logic              push_valid,
    input  logic              push_ready,
    output dsm_pkg::op_word_t push_word
);

    logic              valid_reg;
    logic              valid_next;
    dsm_pkg::op_word_t word_reg;
    dsm_pkg::op_word_t word_next;

    // Accept when the stage is empty or its word moves on this cycle
    assign in_ready = !valid_reg || push_ready;

    // Classify the incoming character
    always_comb
    begin
        word_next.kind       = in_word.req_type;
        word_next.is_star    = (in_word.char_value == dsm_pkg::STAR_CHAR);
        word_next.is_dot     = (in_word.char_value == dsm_pkg::DOT_CHAR);
        word_next.char_value = in_word.char_value;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until it is taken
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign push_valid = valid_reg;
    assign push_word  = word_reg;

endmodule

// ----- rtl/dsm_queue.sv -----
// Short queue of classified words between the front and back stages.
module dsm_queue
#(
    parameter int DEPTH = dsm_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  dsm_pkg::op_word_t      push_word,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output dsm_pkg::op_word_t      pop_word,
    output dsm_pkg::queue_status_t status
);

    localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    dsm_pkg::op_word_t entry_reg [DEPTH];
    logic [PTW-1:0]    wr_ptr_reg;
    logic [PTW-1:0]    wr_ptr_next;
    logic [PTW-1:0]    rd_ptr_reg;
    logic [PTW-1:0]    rd_ptr_next;
    logic [CNW-1:0]    count_reg;
    logic [CNW-1:0]    count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != CNW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_word   = entry_reg[rd_ptr_reg];

    assign status.full  = !push_ready;
    assign status.empty = !pop_valid;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ----- rtl/dsm_back.sv -----
// Back stage: token store, active position set with star closure, result register.
module dsm_back
#(
    parameter int MAX_TOKENS = dsm_pkg::MAX_TOKENS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    output logic               op_ready,
    input  dsm_pkg::op_word_t  op_word,
    output logic               out_valid,
    input  logic               out_ready,
    output dsm_pkg::out_word_t out_word
);

    localparam int CW = $clog2(MAX_TOKENS + 1);
    localparam int IW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int PW = MAX_TOKENS + 1;

    logic [7:0]          atom_reg [MAX_TOKENS];
    logic                dot_reg  [MAX_TOKENS];
    logic                star_reg [MAX_TOKENS];
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                open_reg;
    logic                open_next;
    logic [PW-1:0]       active_reg;
    logic [PW-1:0]       active_next;
    logic                begun_reg;
    logic                begun_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    dsm_pkg::out_word_t  out_word_reg;
    dsm_pkg::out_word_t  out_word_next;

    logic                take;
    logic                wr_atom;
    logic                wr_star;
    logic [CW-1:0]       last_pos;
    logic [IW-1:0]       atom_idx;
    logic [IW-1:0]       last_idx;
    logic [MAX_TOKENS-1:0] lane_ok;
    logic [MAX_TOKENS-1:0] star_mask;
    logic [MAX_TOKENS-1:0] star_add;
    logic [PW-1:0]       stepped;
    logic [PW-1:0]       start_set;

    // Close a position set over starred tokens; a one-bit carry-style chain
    function automatic logic [PW-1:0] close_set(input logic [PW-1:0] s,
                                                 input logic [MAX_TOKENS-1:0] m);
        logic [PW-1:0] r;
        r = s;
        for (int i = 0; i < MAX_TOKENS; i++)
        begin
            r[i+1] = r[i+1] | (r[i] & m[i]);
        end
        return r;
    endfunction

    assign take     = op_valid && op_ready;
    assign op_ready = !out_valid_reg || out_ready;
    assign last_pos = count_reg - 1'b1;
    assign atom_idx = count_reg[IW-1:0];
    assign last_idx = last_pos[IW-1:0];

    // Per-lane token validity and star marks of stored tokens
    always_comb
    begin
        for (int i = 0; i < MAX_TOKENS; i++)
        begin
            lane_ok[i]   = (CW'(i) < count_reg);
            star_mask[i] = lane_ok[i] && star_reg[i];
        end
    end

    // Match one text byte in every lane and advance the position set
    always_comb
    begin
        stepped = '0;
        for (int i = 0; i < MAX_TOKENS; i++)
        begin
            if (active_reg[i] && lane_ok[i] &&
                (dot_reg[i] || (atom_reg[i] == op_word.char_value)))
            begin
                if (star_reg[i])
                begin
                    stepped[i] = 1'b1;
                end
                else
                begin
                    stepped[i+1] = 1'b1;
                end
            end
        end
    end

    assign start_set = close_set(PW'(1), star_mask);

    // Decode the taken word; while no text has begun the active set holds the start set
    always_comb
    begin
        count_next     = count_reg;
        open_next      = open_reg;
        active_next    = active_reg;
        begun_next     = begun_reg;
        ovf_next       = ovf_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && !out_ready;
        wr_atom        = 1'b0;
        wr_star        = 1'b0;
        star_add       = '0;
        if (take)
        begin
            case (op_word.kind)
                dsm_pkg::REQ_CLEAR:
                begin
                    count_next  = '0;
                    open_next   = 1'b0;
                    ovf_next    = 1'b0;
                    begun_next  = 1'b0;
                    active_next = PW'(1);
                end
                dsm_pkg::REQ_PATTERN:
                begin
                    if (!begun_reg)
                    begin
                        if (op_word.is_star && open_reg)
                        begin
                            wr_star             = 1'b1;
                            open_next           = 1'b0;
                            star_add[last_idx]  = 1'b1;
                        end
                        else if (count_reg == CW'(MAX_TOKENS))
                        begin
                            ovf_next  = 1'b1;
                            open_next = 1'b0;
                        end
                        else
                        begin
                            wr_atom    = 1'b1;
                            count_next = count_reg + 1'b1;
                            open_next  = 1'b1;
                        end
                        active_next = close_set(PW'(1), star_mask | star_add);
                    end
                end
                dsm_pkg::REQ_TEXT:
                begin
                    active_next = close_set(stepped, star_mask);
                    begun_next  = 1'b1;
                end
                default:
                begin
                    out_word_next.matched  = active_reg[count_reg] && !ovf_reg;
                    out_word_next.overflow = ovf_reg;
                    out_valid_next         = 1'b1;
                    begun_next             = 1'b0;
                    active_next            = start_set;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            open_reg      <= 1'b0;
            active_reg    <= PW'(1);
            begun_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            open_reg      <= open_next;
            active_reg    <= active_next;
            begun_reg     <= begun_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Store tokens and hold the result word
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        if (wr_atom)
        begin
            atom_reg[atom_idx] <= op_word.char_value;
            dot_reg[atom_idx]  <= op_word.is_dot;
            star_reg[atom_idx] <= 1'b0;
        end
        if (wr_star)
        begin
            star_reg[last_idx] <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ----- rtl/dot_star_pattern_matcher.sv -----
// Top level of the dot-star pattern matcher: front stage, queue and back stage.
// rsp_valid rises once an accepted end-of-text word has passed through the front register,
// then the queue, then the back stage result register.
// Throughput: one word per cycle; the back stage takes a queued word each cycle
// unless its result register holds a word that rsp_ready is not taking.
// Reset clears the token count, overflow flag, text state, queue and valid flags;
// the token store itself is written before it is read and has no reset.
module dot_star_pattern_matcher
#(
    parameter int MAX_TOKENS  = dsm_pkg::MAX_TOKENS_DEF,
    parameter int QUEUE_DEPTH = dsm_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  dsm_pkg::in_word_t  req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output dsm_pkg::out_word_t rsp
);

    logic                   f_valid;
    logic                   f_ready;
    dsm_pkg::op_word_t      f_word;
    logic                   q_valid;
    logic                   q_ready;
    dsm_pkg::op_word_t      q_word;
    dsm_pkg::queue_status_t q_status;

    dsm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req_valid),
        .in_ready   (req_ready),
        .in_word    (req),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_word  (f_word)
    );

    dsm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_word  (f_word),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_word   (q_word),
        .status     (q_status)
    );

    dsm_back #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (q_valid),
        .op_ready  (q_ready),
        .op_word   (q_word),
        .out_valid (rsp_valid),
        .out_ready (rsp_ready),
        .out_word  (rsp)
    );

    // An end word taken by the back stage yields a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready && q_word.kind == dsm_pkg::REQ_END) |=> rsp_valid)
        else $error("end word did not produce a result");

    // Back stage takes nothing while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |-> !q_ready)
        else $error("back stage advanced under a stalled result");

    // Front stalls only when holding a word and the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (f_valid && q_status.full))
        else $error("front stalled without cause");

endmodule
